@@ src/assert_macros.svh @@
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked property that also holds while reset is asserted.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLKD(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

@@ src/pscc_pkg.sv @@
// Types and constants shared by the clamped PID speed controller.
package pscc_pkg;

  localparam int ACC_W      = 21;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 20;
  localparam int CMD_W      = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int FRAC_SHIFT = 8;

  localparam logic [GAIN_W-1:0]  P_GAIN_RST = 24'd3277;
  localparam logic [GAIN_W-1:0]  I_GAIN_RST = 24'd66;
  localparam logic [GAIN_W-1:0]  D_GAIN_RST = 24'd655;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 20'd50000;
  localparam logic [CMD_W-1:0]   FLOOR_RST  = 15'd0;
  localparam logic [CMD_W-1:0]   CEIL_RST   = 15'd25600;

  typedef enum logic [2:0] {
    REG_P_GAIN  = 3'd0,
    REG_I_GAIN  = 3'd1,
    REG_D_GAIN  = 3'd2,
    REG_I_LIMIT = 3'd3,
    REG_FLOOR   = 3'd4,
    REG_CEIL    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  p_gain;
    logic [GAIN_W-1:0]  i_gain;
    logic [GAIN_W-1:0]  d_gain;
    logic [LIMIT_W-1:0] i_limit;
    logic [CMD_W-1:0]   out_floor;
    logic [CMD_W-1:0]   out_ceil;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } back_stat_t;

endpackage

@@ src/pscc_cfg.sv @@
// Configuration register file behind the APB-style port.
module pscc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pscc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pscc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pscc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output pscc_pkg::cfg_t                    cfg
);

  pscc_pkg::cfg_t     cfg_r;
  pscc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = pscc_pkg::reg_idx_t'(paddr[pscc_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain    <= pscc_pkg::P_GAIN_RST;
      cfg_r.i_gain    <= pscc_pkg::I_GAIN_RST;
      cfg_r.d_gain    <= pscc_pkg::D_GAIN_RST;
      cfg_r.i_limit   <= pscc_pkg::LIMIT_RST;
      cfg_r.out_floor <= pscc_pkg::FLOOR_RST;
      cfg_r.out_ceil  <= pscc_pkg::CEIL_RST;
    end else if (wr_en) begin
      case (idx)
        pscc_pkg::REG_P_GAIN:  cfg_r.p_gain    <= pwdata[pscc_pkg::GAIN_W-1:0];
        pscc_pkg::REG_I_GAIN:  cfg_r.i_gain    <= pwdata[pscc_pkg::GAIN_W-1:0];
        pscc_pkg::REG_D_GAIN:  cfg_r.d_gain    <= pwdata[pscc_pkg::GAIN_W-1:0];
        pscc_pkg::REG_I_LIMIT: cfg_r.i_limit   <= pwdata[pscc_pkg::LIMIT_W-1:0];
        pscc_pkg::REG_FLOOR:   cfg_r.out_floor <= pwdata[pscc_pkg::CMD_W-1:0];
        pscc_pkg::REG_CEIL:    cfg_r.out_ceil  <= pwdata[pscc_pkg::CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pscc_pkg::REG_P_GAIN:  prdata = pscc_pkg::CFG_DATA_W'(cfg_r.p_gain);
      pscc_pkg::REG_I_GAIN:  prdata = pscc_pkg::CFG_DATA_W'(cfg_r.i_gain);
      pscc_pkg::REG_D_GAIN:  prdata = pscc_pkg::CFG_DATA_W'(cfg_r.d_gain);
      pscc_pkg::REG_I_LIMIT: prdata = pscc_pkg::CFG_DATA_W'(cfg_r.i_limit);
      pscc_pkg::REG_FLOOR:   prdata = pscc_pkg::CFG_DATA_W'(cfg_r.out_floor);
      pscc_pkg::REG_CEIL:    prdata = pscc_pkg::CFG_DATA_W'(cfg_r.out_ceil);
      default:               prdata = '0;
    endcase
  end

endmodule

@@ src/pscc_front.sv @@
// Front end: takes a request, forms the error, the clamped integral and the derivative.
module pscc_front #(
  parameter int SPEED_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SPEED_BITS-1:0]              in_target_speed,
  input  logic [SPEED_BITS-1:0]              in_measured_speed,
  input  logic [pscc_pkg::LIMIT_W-1:0]       i_limit,
  input  logic                               q_full,
  output logic                               push,
  output logic signed [SPEED_BITS:0]         err,
  output logic signed [pscc_pkg::ACC_W-1:0]  acc_nxt,
  output logic signed [SPEED_BITS+1:0]       deriv
);

  localparam int ERR_W  = SPEED_BITS + 1;
  localparam int DER_W  = SPEED_BITS + 2;
  localparam int ASUM_W = ((ERR_W > pscc_pkg::ACC_W) ? ERR_W : pscc_pkg::ACC_W) + 1;

  logic signed [pscc_pkg::ACC_W-1:0] acc_r;
  logic signed [ERR_W-1:0]           last_err_r;
  logic signed [ASUM_W-1:0]          acc_sum;
  logic signed [ASUM_W-1:0]          lim_w;
  logic signed [ASUM_W-1:0]          acc_sat;
  logic                              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept;

  assign err     = $signed({1'b0, in_target_speed}) - $signed({1'b0, in_measured_speed});
  assign acc_sum = ASUM_W'(err) + ASUM_W'(acc_r);
  assign lim_w   = $signed({{(ASUM_W - pscc_pkg::LIMIT_W){1'b0}}, i_limit});

  always_comb begin
    if (acc_sum > lim_w) begin
      acc_sat = lim_w;
    end else if (acc_sum < -lim_w) begin
      acc_sat = -lim_w;
    end else begin
      acc_sat = acc_sum;
    end
  end

  // The saturated sum always fits the accumulator since the limit is below its range.
  assign acc_nxt = acc_sat[pscc_pkg::ACC_W-1:0];
  assign deriv   = DER_W'(err) - DER_W'(last_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      last_err_r <= '0;
    end else if (accept) begin
      acc_r      <= acc_nxt;
      last_err_r <= err;
    end
  end

endmodule

@@ src/pscc_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
module pscc_queue #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output pscc_pkg::q_stat_t stat
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r;
  logic [ADDR_W-1:0] rd_ptr_r;
  logic [ADDR_W:0]   count_r;
  logic [ADDR_W:0]   count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (ADDR_W + 1)'(DEPTH));
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/pscc_back.sv @@
// Back end: gain multiplies, term sum, floor shift and output clamp, with a result register.
module pscc_back #(
  parameter int SPEED_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  output logic                                    pop,
  input  logic signed [SPEED_BITS:0]              err,
  input  logic signed [pscc_pkg::ACC_W-1:0]       acc,
  input  logic signed [SPEED_BITS+1:0]            deriv,
  input  pscc_pkg::cfg_t                          cfg,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [pscc_pkg::CMD_W-1:0]              out_valve_command,
  output pscc_pkg::back_stat_t                    stat
);

  localparam int ERR_W = SPEED_BITS + 1;
  localparam int DER_W = SPEED_BITS + 2;
  localparam int PW    = pscc_pkg::GAIN_W + 1 + ERR_W;
  localparam int IW    = pscc_pkg::GAIN_W + 1 + pscc_pkg::ACC_W;
  localparam int DW    = pscc_pkg::GAIN_W + 1 + DER_W;
  localparam int MW1   = (PW > IW) ? PW : IW;
  localparam int MW    = (MW1 > DW) ? MW1 : DW;
  localparam int SUM_W = MW + 2;

  logic                    s1_v_r;
  logic                    s2_v_r;
  logic                    out_v_r;
  logic signed [PW-1:0]    p_r;
  logic signed [IW-1:0]    i_r;
  logic signed [DW-1:0]    d_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W-1:0] ceil_w;
  logic signed [SUM_W-1:0] floor_w;
  logic signed [SUM_W-1:0] clamped;
  logic [pscc_pkg::CMD_W-1:0] cmd_r;
  logic                    out_adv;
  logic                    s2_adv;
  logic                    s1_adv;

  assign out_adv = !out_v_r || !out_stall;
  assign s2_adv  = !s2_v_r || out_adv;
  assign s1_adv  = !s1_v_r || s2_adv;
  assign pop     = !q_empty && s1_adv;

  assign shifted = sum_r >>> pscc_pkg::FRAC_SHIFT;
  assign ceil_w  = $signed({{(SUM_W - pscc_pkg::CMD_W){1'b0}}, cfg.out_ceil});
  assign floor_w = $signed({{(SUM_W - pscc_pkg::CMD_W){1'b0}}, cfg.out_floor});

  // Ceiling first, then floor, so the floor wins when the two cross.
  always_comb begin
    clamped = shifted;
    if (clamped > ceil_w) begin
      clamped = ceil_w;
    end
    if (clamped < floor_w) begin
      clamped = floor_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= pop;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_r <= $signed({1'b0, cfg.p_gain}) * err;
      i_r <= $signed({1'b0, cfg.i_gain}) * acc;
      d_r <= $signed({1'b0, cfg.d_gain}) * deriv;
    end
    if (s2_adv && s1_v_r) begin
      sum_r <= SUM_W'(p_r) + SUM_W'(i_r) + SUM_W'(d_r);
    end
    if (out_adv && s2_v_r) begin
      cmd_r <= clamped[pscc_pkg::CMD_W-1:0];
    end
  end

  assign out_valid         = out_v_r;
  assign out_valve_command = cmd_r;
  assign stat.s1_valid     = s1_v_r;
  assign stat.s2_valid     = s2_v_r;

endmodule

@@ src/pid_speed_controller_clamped_unit.sv @@
// Top level of the clamped positional PID speed controller.
`include "assert_macros.svh"

// Takes one control request per cycle while the queue is not full, and returns one valve
// command per request, in order. The front end updates the integral accumulator and the
// stored error in the cycle the request is taken; that single add-and-clamp is the loop that
// sets the rate of one request per clock. A queue of 2**QUEUE_ADDR_BITS entries decouples it
// from the back end, whose multiply and sum registers and the result register, which takes
// the clamped command, carry each command to the output. The user must write gains and
// limits only while no request is in flight; the block itself does not enforce this.
module pid_speed_controller_clamped_unit #(
  parameter int SPEED_BITS      = 16,
  parameter int QUEUE_ADDR_BITS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SPEED_BITS-1:0]             in_target_speed,
  input  logic [SPEED_BITS-1:0]             in_measured_speed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pscc_pkg::CMD_W-1:0]        out_valve_command,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pscc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pscc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pscc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int ERR_W  = SPEED_BITS + 1;
  localparam int DER_W  = SPEED_BITS + 2;
  localparam int DATA_W = ERR_W + pscc_pkg::ACC_W + DER_W;

  pscc_pkg::cfg_t                    cfg;
  pscc_pkg::q_stat_t                 q_stat;
  pscc_pkg::back_stat_t              bk_stat;
  logic                              push;
  logic                              pop;
  logic signed [ERR_W-1:0]           f_err;
  logic signed [pscc_pkg::ACC_W-1:0] f_acc;
  logic signed [DER_W-1:0]           f_deriv;
  logic [DATA_W-1:0]                 q_wdata;
  logic [DATA_W-1:0]                 q_rdata;
  logic signed [ERR_W-1:0]           b_err;
  logic signed [pscc_pkg::ACC_W-1:0] b_acc;
  logic signed [DER_W-1:0]           b_deriv;

  pscc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pscc_front #(
    .SPEED_BITS (SPEED_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .i_limit           (cfg.i_limit),
    .q_full            (q_stat.full),
    .push              (push),
    .err               (f_err),
    .acc_nxt           (f_acc),
    .deriv             (f_deriv)
  );

  assign q_wdata = {f_err, f_acc, f_deriv};

  pscc_queue #(
    .DATA_W (DATA_W),
    .ADDR_W (QUEUE_ADDR_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign b_err   = q_rdata[DATA_W-1 -: ERR_W];
  assign b_acc   = q_rdata[DER_W +: pscc_pkg::ACC_W];
  assign b_deriv = q_rdata[DER_W-1:0];

  pscc_back #(
    .SPEED_BITS (SPEED_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_stat.empty),
    .pop               (pop),
    .err               (b_err),
    .acc               (b_acc),
    .deriv             (b_deriv),
    .cfg               (cfg),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_valve_command (out_valve_command),
    .stat              (bk_stat)
  );

  // Right after reset nothing is in flight and the front end is open.
  `ASSERT_CLK(a_reset_clean, clk, !rst_n |=> !out_valid && !in_stall)
  // A result only appears after the sum stage held a request.
  `ASSERT_CLKD(a_out_from_sum, clk, rst_n, $rose(out_valid) |-> $past(bk_stat.s2_valid))
  // The multiply stage only fills from a queue that held a request.
  `ASSERT_CLKD(a_mul_from_queue, clk, rst_n, $rose(bk_stat.s1_valid) |-> $past(!q_stat.empty))

endmodule

@@ test/pid_speed_controller_clamped_unit_checker.sv @@
// Checker for the clamped PID speed controller: predicts every valve command and register read and compares them.
module pid_speed_controller_clamped_unit_checker #(
  parameter int SPEED_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [SPEED_BITS-1:0]             in_target_speed,
  input  logic [SPEED_BITS-1:0]             in_measured_speed,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [pscc_pkg::CMD_W-1:0]        out_valve_command,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pscc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pscc_pkg::CFG_DATA_W-1:0]   pwdata,
  input  logic [pscc_pkg::CFG_DATA_W-1:0]   prdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);
  import pscc_pkg::*;

  cfg_t                        regs;
  logic signed [ACC_W-1:0]     integ_err;
  logic signed [SPEED_BITS:0]  prev_err;
  logic [CMD_W-1:0]            valve_expected[$];
  logic [CMD_W-1:0]            want;
  logic [CFG_DATA_W-1:0]       rd_want;
  logic [CFG_ADDR_W-3:0]       reg_sel;

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

  // One control step: updates the integral and the stored error, returns the clamped command.
  function automatic logic [CMD_W-1:0] next_valve_command(
    input logic [SPEED_BITS-1:0] target,
    input logic [SPEED_BITS-1:0] measured
  );
    longint tgt, meas, err, lim, acc, deriv, kp, ki, kd, total, cmd, hi, lo;
    tgt = longint'(target);
    meas = longint'(measured);
    err = tgt - meas;
    lim = longint'(regs.i_limit);
    acc = longint'(integ_err) + err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    deriv = err - longint'(prev_err);
    integ_err = acc[ACC_W-1:0];
    prev_err = err[SPEED_BITS:0];
    kp = longint'(regs.p_gain);
    ki = longint'(regs.i_gain);
    kd = longint'(regs.d_gain);
    total = kp * err + ki * acc + kd * deriv;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    cmd = total >>> FRAC_SHIFT;
    hi = longint'(regs.out_ceil);
    lo = longint'(regs.out_floor);
    if (cmd > hi) cmd = hi;
    if (cmd < lo) cmd = lo;
    return cmd[CMD_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.p_gain = P_GAIN_RST;
      regs.i_gain = I_GAIN_RST;
      regs.d_gain = D_GAIN_RST;
      regs.i_limit = LIMIT_RST;
      regs.out_floor = FLOOR_RST;
      regs.out_ceil = CEIL_RST;
      integ_err = '0;
      prev_err = '0;
      valve_expected.delete();
    end else begin
      if (psel && penable && pready && paddr[1:0] == 2'b00) begin
        reg_sel = paddr[CFG_ADDR_W-1:2];
        if (pwrite) begin
          case (reg_sel)
            REG_P_GAIN:  regs.p_gain = pwdata[GAIN_W-1:0];
            REG_I_GAIN:  regs.i_gain = pwdata[GAIN_W-1:0];
            REG_D_GAIN:  regs.d_gain = pwdata[GAIN_W-1:0];
            REG_I_LIMIT: regs.i_limit = pwdata[LIMIT_W-1:0];
            REG_FLOOR:   regs.out_floor = pwdata[CMD_W-1:0];
            REG_CEIL:    regs.out_ceil = pwdata[CMD_W-1:0];
            default: ;
          endcase
        end else if (reg_sel <= REG_CEIL) begin
          case (reg_sel)
            REG_P_GAIN:  rd_want = CFG_DATA_W'(regs.p_gain);
            REG_I_GAIN:  rd_want = CFG_DATA_W'(regs.i_gain);
            REG_D_GAIN:  rd_want = CFG_DATA_W'(regs.d_gain);
            REG_I_LIMIT: rd_want = CFG_DATA_W'(regs.i_limit);
            REG_FLOOR:   rd_want = CFG_DATA_W'(regs.out_floor);
            default:     rd_want = CFG_DATA_W'(regs.out_ceil);
          endcase
          if (prdata !== rd_want) begin
            fail_count++;
            $display("%0t: register read at 0x%0h expected 0x%0h, got 0x%0h",
                     $time, paddr, rd_want, prdata);
          end
        end
      end

      if (out_valid && !out_stall) begin
        if (valve_expected.size() == 0) begin
          fail_count++;
          $display("%0t: valve_command expected none, got %0d", $time, out_valve_command);
        end else begin
          want = valve_expected.pop_front();
          checked++;
          if (out_valve_command !== want) begin
            fail_count++;
            $display("%0t: valve_command expected %0d, got %0d",
                     $time, want, out_valve_command);
          end
        end
      end

      if (in_valid && !in_stall)
        valve_expected.push_back(next_valve_command(in_target_speed, in_measured_speed));
    end
    pending = valve_expected.size();
  end

endmodule

@@ test/pid_speed_controller_clamped_unit_tb.sv @@
// Testbench top for the clamped PID speed controller: stimulus, register settings and verdict.
module pid_speed_controller_clamped_unit_tb;
  import pscc_pkg::*;

  localparam int SPEED_BITS     = 16;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 185;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_LO = CFG_ADDR_W'(24);
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_HI = CFG_ADDR_W'(28);

  typedef enum int {
    SET_TYPICAL,
    SET_WIDE,
    SET_NO_INTEGRAL,
    SET_FLOOR_WINS,
    SET_EXTREMES,
    SET_RESET_VALUES
  } setting_kind_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SPEED_BITS-1:0]   in_target_speed = '0;
  logic [SPEED_BITS-1:0]   in_measured_speed = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CMD_W-1:0]        out_valve_command;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int run_left = 0;
  bit run_up = 1'b0;

  pid_speed_controller_clamped_unit #(.SPEED_BITS(SPEED_BITS)) dut (.*);

  pid_speed_controller_clamped_unit_checker #(.SPEED_BITS(SPEED_BITS)) cmd_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pid_speed_controller_clamped_unit_tb: errors");
      $finish;
    end
  end

  // Result side: random stall bursts at a per-phase rate.
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_t r);
    return CFG_ADDR_W'({r, 2'b00});
  endfunction

  task automatic send_request(input logic [SPEED_BITS-1:0] tgt,
                              input logic [SPEED_BITS-1:0] meas);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_speed <= tgt;
    in_measured_speed <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Holds the sender until every command is back; sampled at the falling edge to avoid races.
  task automatic wait_for_commands(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back_settings();
    for (int k = REG_P_GAIN; k <= REG_CEIL; k++)
      apb_access(1'b0, reg_addr(reg_idx_t'(k)), '0);
  endtask

  task automatic write_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] lim,
                                input logic [31:0] lo, input logic [31:0] hi);
    apb_access(1'b1, reg_addr(REG_P_GAIN), kp);
    apb_access(1'b1, reg_addr(REG_I_GAIN), ki);
    apb_access(1'b1, reg_addr(REG_D_GAIN), kd);
    apb_access(1'b1, reg_addr(REG_I_LIMIT), lim);
    apb_access(1'b1, reg_addr(REG_FLOOR), lo);
    apb_access(1'b1, reg_addr(REG_CEIL), hi);
    settings++;
    read_back_settings();
  endtask

  task automatic apply_setting(input setting_kind_t kind);
    case (kind)
      SET_TYPICAL:
        write_settings($urandom_range(0, 20000), $urandom_range(0, 2000),
                       $urandom_range(0, 20000), $urandom_range(0, 200000),
                       $urandom_range(0, 5000), $urandom_range(15000, 25600));
      SET_WIDE:
        write_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      SET_NO_INTEGRAL:
        write_settings($urandom_range(0, 20000), $urandom, $urandom_range(0, 20000),
                       32'd0, 32'd0, 32'd25600);
      SET_FLOOR_WINS:
        write_settings($urandom_range(0, 20000), $urandom_range(0, 2000),
                       $urandom_range(0, 20000), $urandom_range(0, 200000),
                       $urandom_range(12801, 25600), $urandom_range(0, 12800));
      SET_EXTREMES:
        write_settings($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0,
                       $urandom_range(0, 1) ? '1 : '0, '1, 32'd0, 32'd25600);
      default:
        write_settings(P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, LIMIT_RST, FLOOR_RST, CEIL_RST);
    endcase
  endtask

  // Mostly a speed loop near its target, with the error sign held over runs so the
  // integral winds up; the rest is full-range noise, extreme speeds and zero error.
  task automatic pick_request(output logic [SPEED_BITS-1:0] tgt,
                              output logic [SPEED_BITS-1:0] meas);
    int mode;
    int delta;
    int val;
    mode = $urandom_range(0, 99);
    if (run_left == 0) begin
      run_left = $urandom_range(5, 60);
      run_up = 1'($urandom_range(0, 1));
    end
    run_left--;
    tgt = SPEED_BITS'($urandom);
    if (mode < 60) begin
      delta = $urandom_range(0, 3000);
      val = run_up ? int'(tgt) - delta : int'(tgt) + delta;
      if (val < 0) val = 0;
      if (val > int'(SPEED_MAX)) val = int'(SPEED_MAX);
      meas = SPEED_BITS'(val);
    end else if (mode < 75) begin
      meas = SPEED_BITS'($urandom);
    end else if (mode < 85) begin
      tgt = $urandom_range(0, 1) ? SPEED_MAX : '0;
      meas = $urandom_range(0, 1) ? SPEED_MAX : '0;
    end else begin
      meas = tgt;
    end
  endtask

  initial begin : stimulus
    logic [SPEED_BITS-1:0] tgt;
    logic [SPEED_BITS-1:0] meas;
    setting_kind_t kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 20;
    stall_pct = 10;

    // Reset values of the registers, then extreme speeds and a small windup.
    read_back_settings();
    send_request(0, 0);
    send_request(SPEED_MAX, 0);
    send_request(0, SPEED_MAX);
    send_request(SPEED_MAX, SPEED_MAX);
    send_request(1200, 1000);
    send_request(1200, 1000);
    send_request(800, 1000);
    send_request(0, 0);
    wait_for_commands(SETTLE_CYCLES);

    // Writes to unmapped addresses must leave every register alone.
    apb_access(1'b1, UNMAPPED_ADDR_LO, '1);
    apb_access(1'b1, UNMAPPED_ADDR_HI, '1);
    // Zero integral limit with the largest integral gain: the integral must stay at zero.
    write_settings(P_GAIN_RST, '1, D_GAIN_RST, 32'd0, 32'd0, 32'd25600);
    send_request(40000, 0);
    send_request(40000, 0);
    send_request(0, 40000);
    wait_for_commands(SETTLE_CYCLES);

    // Floor above the ceiling: the floor is applied last and wins.
    write_settings(P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, '1, 32'd20000, 32'd5000);
    send_request(0, SPEED_MAX);
    send_request(SPEED_MAX, 0);
    send_request(0, 0);
    wait_for_commands(SETTLE_CYCLES);

    // All-ones data: each register keeps only its own width.
    write_settings('1, '1, '1, '1, 32'd0, '1);
    send_request(SPEED_MAX, 0);
    send_request(0, SPEED_MAX);
    send_request(1, 0);
    send_request(0, 0);
    wait_for_commands(SETTLE_CYCLES);

    write_settings(32'd0, 32'd0, 32'd0, LIMIT_RST, '1, 32'd0);
    send_request(100, 0);
    send_request(0, 100);

    for (int ph = 0; ph < PHASES; ph++) begin
      kind = setting_kind_t'(ph % 5);
      if (ph == PHASES - 1) kind = SET_RESET_VALUES;
      wait_for_commands(SETTLE_CYCLES);
      apply_setting(kind);
      if (ph == PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 15;
        endcase
      end
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        if (k == PHASE_REQUESTS / 2) wait_for_commands(1);
        pick_request(tgt, meas);
        send_request(tgt, meas);
      end
    end

    wait_for_commands(SETTLE_CYCLES);
    $display("Sent %0d speed requests under %0d register settings; %0d commands compared.",
             sent, settings, checked);
    $display("Covered extreme speeds, windup, zero integral limit, floor over ceiling, masking.");
    if (fail_count == 0) begin
      $display("pid_speed_controller_clamped_unit_tb: clean");
    end else begin
      $display("pid_speed_controller_clamped_unit_tb: errors");
    end
    $finish;
  end

endmodule
